// File: src/avfl_pkg.sv
// Shared types, constants and calibration tables for the air velocity linearizer.
package avfl_pkg;

  localparam int RAW_W  = 16;  // raw reading {byte1, byte2}
  localparam int TBL_W  = 12;  // table raw points fit below 4096
  localparam int VEL_W  = 14;  // velocity in mm/s
  localparam int IDX_W  = 4;   // table index, up to 13 points
  localparam int DX_W   = 10;  // largest gap between raw points is 794
  localparam int DV_W   = 11;  // largest velocity step is 2000
  localparam int PROD_W = DX_W + DV_W;
  localparam int ALU_W  = RAW_W + 1;

  localparam int LAST_A = 8;
  localparam int LAST_B = 12;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_READ_FAIL = 2'd1;
  localparam status_t STATUS_CSUM_FAIL = 2'd2;

  function automatic logic [IDX_W-1:0] tbl_last(input logic model);
    tbl_last = model ? IDX_W'(LAST_B) : IDX_W'(LAST_A);
  endfunction

  function automatic logic [TBL_W-1:0] tbl_raw(input logic model, input logic [IDX_W-1:0] idx);
    logic [TBL_W-1:0] r;
    r = '0;
    if (!model) begin
      case (idx)
        4'd0: r = 12'd409;
        4'd1: r = 12'd915;
        4'd2: r = 12'd1522;
        4'd3: r = 12'd2066;
        4'd4: r = 12'd2523;
        4'd5: r = 12'd2908;
        4'd6: r = 12'd3256;
        4'd7: r = 12'd3572;
        4'd8: r = 12'd3686;
        default: r = '0;
      endcase
    end else begin
      case (idx)
        4'd0:  r = 12'd409;
        4'd1:  r = 12'd1203;
        4'd2:  r = 12'd1597;
        4'd3:  r = 12'd1908;
        4'd4:  r = 12'd2187;
        4'd5:  r = 12'd2400;
        4'd6:  r = 12'd2629;
        4'd7:  r = 12'd2801;
        4'd8:  r = 12'd3006;
        4'd9:  r = 12'd3178;
        4'd10: r = 12'd3309;
        4'd11: r = 12'd3563;
        4'd12: r = 12'd3686;
        default: r = '0;
      endcase
    end
    tbl_raw = r;
  endfunction

  function automatic logic [VEL_W-1:0] tbl_vel(input logic model, input logic [IDX_W-1:0] idx);
    logic [VEL_W-1:0] v;
    v = '0;
    if (!model) begin
      case (idx)
        4'd0: v = 14'd0;
        4'd1: v = 14'd1070;
        4'd2: v = 14'd2010;
        4'd3: v = 14'd3000;
        4'd4: v = 14'd3970;
        4'd5: v = 14'd4960;
        4'd6: v = 14'd5980;
        4'd7: v = 14'd6990;
        4'd8: v = 14'd7230;
        default: v = '0;
      endcase
    end else begin
      case (idx)
        4'd0:  v = 14'd0;
        4'd1:  v = 14'd2000;
        4'd2:  v = 14'd3000;
        4'd3:  v = 14'd4000;
        4'd4:  v = 14'd5000;
        4'd5:  v = 14'd6000;
        4'd6:  v = 14'd7000;
        4'd7:  v = 14'd8000;
        4'd8:  v = 14'd9000;
        4'd9:  v = 14'd10000;
        4'd10: v = 14'd11000;
        4'd11: v = 14'd13000;
        4'd12: v = 14'd15000;
        default: v = '0;
      endcase
    end
    tbl_vel = v;
  endfunction

endpackage

// File: src/air_velocity_frame_linearizer.sv
// Sequence: a bad frame goes straight to the output state with its result registered; a clamped
// reading is resolved in the table search (one point per cycle); an inner reading runs the table
// search, the difference steps DX, DV and DR, a restoring divide and a sum step.
// Throughput: one frame at a time; in_tready is high only while the sequencer is idle and the
// previous result has been taken. One subtract/compare unit does search, difference and divide.
// Reset: rst_n synchronous active low; clears sequencer, output valid and model_select.
module air_velocity_frame_linearizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // model_select
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // frame_byte_0 .. frame_byte_4, 8 bits each
  input  logic        in_tuser,      // read_ok
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // velocity_mm_per_s [13:0], zero pad [15:14]
  output logic [2:0]  out_tuser      // status [1:0], warning [2]
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_DX     = 3'd2;
  localparam logic [2:0] S_DV     = 3'd3;
  localparam logic [2:0] S_DR     = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_SUM    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam int CNT_W = $clog2(avfl_pkg::PROD_W);

  logic [2:0]                      state_r;
  logic                            model_r;
  logic [avfl_pkg::RAW_W-1:0]      raw_r;
  logic [avfl_pkg::IDX_W-1:0]      k_r;
  logic [avfl_pkg::IDX_W-1:0]      km1;
  logic [avfl_pkg::DX_W-1:0]       dx_r;
  logic [avfl_pkg::DV_W-1:0]       dv_r;
  logic [avfl_pkg::DX_W-1:0]       dr_r;
  logic [avfl_pkg::DX_W-1:0]       rem_r;
  logic [avfl_pkg::PROD_W-1:0]     quo_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            out_valid_r;
  avfl_pkg::status_t               out_status_r;
  logic [avfl_pkg::VEL_W-1:0]      out_vel_r;

  logic [7:0]                      csum;
  avfl_pkg::status_t               status_nxt;
  logic [avfl_pkg::RAW_W-1:0]      alu_a;
  logic [avfl_pkg::RAW_W-1:0]      alu_b;
  logic [avfl_pkg::ALU_W-1:0]      alu_diff;
  logic                            alu_ge;
  logic [avfl_pkg::IDX_W-1:0]      last;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_vel_r};
  assign out_tuser  = {(out_status_r != avfl_pkg::STATUS_OK), out_status_r};

  assign km1  = k_r - 1'b1;
  assign last = avfl_pkg::tbl_last(model_r);

  assign csum = in_tdata[7:0] + in_tdata[15:8] + in_tdata[23:16] + in_tdata[31:24]
              + in_tdata[39:32];

  always_comb begin
    if (!in_tuser) status_nxt = avfl_pkg::STATUS_READ_FAIL;
    else if (csum != 8'd0) status_nxt = avfl_pkg::STATUS_CSUM_FAIL;
    else status_nxt = avfl_pkg::STATUS_OK;
  end

  // shared subtract/compare unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_SEARCH: begin
        alu_a = avfl_pkg::RAW_W'(avfl_pkg::tbl_raw(model_r, k_r));
        alu_b = raw_r;
      end
      S_DX: begin
        alu_a = raw_r;
        alu_b = avfl_pkg::RAW_W'(avfl_pkg::tbl_raw(model_r, km1));
      end
      S_DV: begin
        alu_a = avfl_pkg::RAW_W'(avfl_pkg::tbl_vel(model_r, k_r));
        alu_b = avfl_pkg::RAW_W'(avfl_pkg::tbl_vel(model_r, km1));
      end
      S_DR: begin
        alu_a = avfl_pkg::RAW_W'(avfl_pkg::tbl_raw(model_r, k_r));
        alu_b = avfl_pkg::RAW_W'(avfl_pkg::tbl_raw(model_r, km1));
      end
      S_DIV: begin
        alu_a = avfl_pkg::RAW_W'({rem_r, quo_r[avfl_pkg::PROD_W-1]});
        alu_b = avfl_pkg::RAW_W'(dr_r);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[avfl_pkg::ALU_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= 1'b0;
    end else if (cfg_we) begin
      model_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_r        <= {in_tdata[15:8], in_tdata[23:16]};
            out_status_r <= status_nxt;
            out_vel_r    <= '0;
            k_r          <= '0;
            if (status_nxt != avfl_pkg::STATUS_OK) begin
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          // first point at or above the reading; clamp at either end
          if (alu_ge) begin
            if (k_r == '0) begin
              out_vel_r   <= avfl_pkg::tbl_vel(model_r, k_r);
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_DX;
            end
          end else if (k_r == last) begin
            out_vel_r   <= avfl_pkg::tbl_vel(model_r, k_r);
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DX: begin
          dx_r    <= alu_diff[avfl_pkg::DX_W-1:0];
          state_r <= S_DV;
        end
        S_DV: begin
          dv_r    <= alu_diff[avfl_pkg::DV_W-1:0];
          state_r <= S_DR;
        end
        S_DR: begin
          dr_r    <= alu_diff[avfl_pkg::DX_W-1:0];
          quo_r   <= avfl_pkg::PROD_W'(dx_r) * avfl_pkg::PROD_W'(dv_r);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem_r <= alu_ge ? alu_diff[avfl_pkg::DX_W-1:0] : alu_a[avfl_pkg::DX_W-1:0];
          quo_r <= {quo_r[avfl_pkg::PROD_W-2:0], alu_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(avfl_pkg::PROD_W - 1)) state_r <= S_SUM;
        end
        S_SUM: begin
          out_vel_r   <= avfl_pkg::tbl_vel(model_r, km1) + quo_r[avfl_pkg::VEL_W-1:0];
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_fail_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tdata == 16'd0))
    else $error("nonzero velocity on a failed frame");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (k_r <= last))
    else $error("table search ran past the last point");

  a_valid_only_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == S_OUT))
    else $error("result valid outside the output state");

endmodule
